// ----- src/ehma_pkg.sv -----
// ehma_pkg: shared types, constants and helpers of the exponential hull moving average
// used by the controller, the datapath and the top level; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ehma_pkg;

  // word widths
  localparam int SAMPLE_W = 32;
  localparam int GAIN_W   = 17;
  localparam int CFG_IDX_W = 2;

  // gain register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HALF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_FULL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_ROOT = 2'd2;

  // gain reset value, 1.0 in q1.16
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

  // saturation bounds
  localparam logic signed [SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;

  // rounding offset, half an lsb after the q16 shift
  localparam logic signed [50:0] ROUND_HALF = 51'sd32768;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_MUL_HALF,
    ST_MUL_FULL,
    ST_UPD_FULL,
    ST_TARGET,
    ST_MUL_HULL,
    ST_UPD_HULL,
    ST_WRITE
  } state_t;

  // which average the shared multiplier or the accumulator works on
  typedef enum logic [1:0] {
    SEL_HALF,
    SEL_FULL,
    SEL_HULL
  } avg_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load_sample;
    logic     init_avgs;
    logic     mul_en;
    avg_sel_t mul_sel;
    logic     upd_en;
    avg_sel_t upd_sel;
    logic     tgt_en;
    logic     out_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic primed;
  } dp_status_t;

  // clamp a wide signed value to the q16.16 range
  function automatic logic signed [SAMPLE_W-1:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'(Q_MAX);
    lo = 36'(Q_MIN);
    if (v > hi) begin
      return Q_MAX;
    end else if (v < lo) begin
      return Q_MIN;
    end else begin
      return v[SAMPLE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- src/ehma_dp.sv -----
// ehma_dp: averages, gain registers, shared multiplier and output word register
// depends on ehma_pkg; driven by ehma_ctrl through dp_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module ehma_dp (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  ehma_pkg::dp_cmd_t                   cmd,
  output ehma_pkg::dp_status_t                status,
  input  wire  signed [ehma_pkg::SAMPLE_W-1:0] in_sample,
  input  wire                                 cfg_wr,
  input  wire         [ehma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire         [ehma_pkg::GAIN_W-1:0]   cfg_data,
  output logic signed [ehma_pkg::SAMPLE_W-1:0] out_hull_value
);
  import ehma_pkg::*;

  logic                       primed_r;
  logic [GAIN_W-1:0]          gain_half_r;
  logic [GAIN_W-1:0]          gain_full_r;
  logic [GAIN_W-1:0]          gain_root_r;
  logic signed [SAMPLE_W-1:0] sample_r;
  logic signed [SAMPLE_W-1:0] avg_half_r;
  logic signed [SAMPLE_W-1:0] avg_full_r;
  logic signed [SAMPLE_W-1:0] avg_hull_r;
  logic signed [SAMPLE_W-1:0] target_r;
  logic signed [50:0]         prod_r;
  logic signed [SAMPLE_W-1:0] out_r;

  logic signed [SAMPLE_W-1:0] mul_avg;
  logic signed [SAMPLE_W-1:0] mul_tgt;
  logic [GAIN_W-1:0]          mul_gain;
  logic signed [32:0]         diff;
  logic signed [50:0]         prod_nxt;
  logic signed [SAMPLE_W-1:0] upd_avg;
  logic signed [50:0]         rounded;
  logic signed [34:0]         delta;
  logic signed [35:0]         upd_sum;
  logic signed [SAMPLE_W-1:0] upd_nxt;
  logic signed [35:0]         tgt_sum;
  logic signed [SAMPLE_W-1:0] target_nxt;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      SEL_HALF: begin
        mul_avg  = avg_half_r;
        mul_tgt  = sample_r;
        mul_gain = gain_half_r;
      end
      SEL_FULL: begin
        mul_avg  = avg_full_r;
        mul_tgt  = sample_r;
        mul_gain = gain_full_r;
      end
      SEL_HULL: begin
        mul_avg  = avg_hull_r;
        mul_tgt  = target_r;
        mul_gain = gain_root_r;
      end
      default: begin
        mul_avg  = avg_half_r;
        mul_tgt  = sample_r;
        mul_gain = gain_half_r;
      end
    endcase
  end

  // exact difference and product, 33 by 18 bits signed
  assign diff     = {mul_tgt[SAMPLE_W-1], mul_tgt} - {mul_avg[SAMPLE_W-1], mul_avg};
  assign prod_nxt = diff * $signed({1'b0, mul_gain});

  // accumulate: round the q16 product, add to the average, clamp
  always_comb begin
    case (cmd.upd_sel)
      SEL_HALF: upd_avg = avg_half_r;
      SEL_FULL: upd_avg = avg_full_r;
      SEL_HULL: upd_avg = avg_hull_r;
      default:  upd_avg = avg_half_r;
    endcase
  end

  assign rounded = prod_r + ROUND_HALF;
  assign delta   = rounded[50:16];
  assign upd_sum = 36'(upd_avg) + 36'(delta);
  assign upd_nxt = sat32(upd_sum);

  // hull target from the new half and full averages
  assign tgt_sum    = (36'(avg_half_r) <<< 1) - 36'(avg_full_r);
  assign target_nxt = sat32(tgt_sum);

  // gain registers and primed flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_half_r <= GAIN_ONE;
      gain_full_r <= GAIN_ONE;
      gain_root_r <= GAIN_ONE;
      primed_r    <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_index)
          CFG_GAIN_HALF: gain_half_r <= cfg_data;
          CFG_GAIN_FULL: gain_full_r <= cfg_data;
          CFG_GAIN_ROOT: gain_root_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.init_avgs) begin
        primed_r <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      sample_r <= in_sample;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.tgt_en) begin
      target_r <= target_nxt;
    end
    if (cmd.init_avgs) begin
      avg_half_r <= sample_r;
      avg_full_r <= sample_r;
      avg_hull_r <= sample_r;
    end else if (cmd.upd_en) begin
      case (cmd.upd_sel)
        SEL_HALF: avg_half_r <= upd_nxt;
        SEL_FULL: avg_full_r <= upd_nxt;
        SEL_HULL: avg_hull_r <= upd_nxt;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_r <= avg_hull_r;
    end
  end

  assign status.primed  = primed_r;
  assign out_hull_value = out_r;

endmodule

`default_nettype wire

// ----- src/ehma_ctrl.sv -----
// ehma_ctrl: sequencer that steps the datapath through the three average updates
// depends on ehma_pkg; drives ehma_dp through dp_cmd_t and owns the handshakes
`timescale 1ns / 1ps
`default_nettype none

module ehma_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire                   out_stall,
  input  ehma_pkg::dp_status_t  status,
  output ehma_pkg::dp_cmd_t     cmd
);
  import ehma_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // output word slot is free when empty or being taken
  assign out_free = !out_valid_r || !out_stall;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt       = state_r;
    cmd             = '0;
    cmd.mul_sel     = SEL_HALF;
    cmd.upd_sel     = SEL_HALF;
    out_valid_nxt   = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_sample = 1'b1;
          state_nxt       = status.primed ? ST_MUL_HALF : ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init_avgs = 1'b1;
        state_nxt     = ST_WRITE;
      end
      ST_MUL_HALF: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_HALF;
        state_nxt   = ST_MUL_FULL;
      end
      ST_MUL_FULL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_FULL;
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = SEL_HALF;
        state_nxt   = ST_UPD_FULL;
      end
      ST_UPD_FULL: begin
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = SEL_FULL;
        state_nxt   = ST_TARGET;
      end
      ST_TARGET: begin
        cmd.tgt_en = 1'b1;
        state_nxt  = ST_MUL_HULL;
      end
      ST_MUL_HULL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = SEL_HULL;
        state_nxt   = ST_UPD_HULL;
      end
      ST_UPD_HULL: begin
        cmd.upd_en  = 1'b1;
        cmd.upd_sel = SEL_HULL;
        state_nxt   = ST_WRITE;
      end
      ST_WRITE: begin
        // hold the result until the output slot frees up
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- src/exponential_hull_moving_average_top.sv -----
// exponential_hull_moving_average_top: top level of the hull moving average block
// depends on ehma_pkg, ehma_ctrl and ehma_dp
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+-------------------------
//   input   | in_valid, in_stall, in_sample           | valid high, stall low
//   result  | out_valid, out_stall, out_hull_value    | valid high, stall low
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | valid and ready high
//
// a primed word is accepted, then runs three multiplies on one shared 33x18 multiplier
// and three accumulates (half accumulate overlaps full multiply), a target step and the
// output load; the first word after reset is only initialised and loaded; the result
// sits in an output register, so the input is free again while it waits; a long
// out_stall only holds the next word in its final cycle
// synchronous active-low reset sets gains to 1.0 and clears the primed flag
// cfg_ready is always high; the user must write gains while idle, unchecked by the block
`timescale 1ns / 1ps
`default_nettype none

module exponential_hull_moving_average_top (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [ehma_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic signed [ehma_pkg::SAMPLE_W-1:0]  out_hull_value,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire         [ehma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire         [ehma_pkg::GAIN_W-1:0]    cfg_data
);
  import ehma_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // gain writes never wait
  assign cfg_ready = 1'b1;

  ehma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  ehma_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_sample      (in_sample),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_hull_value (out_hull_value)
  );

endmodule

`default_nettype wire

// ----- src/ehma_chk.sv -----
// ehma_chk: port-level checker for the hull moving average top level
// depends on ehma_pkg; attached to exponential_hull_moving_average_top by bind
`timescale 1ns / 1ps
`default_nettype none

module ehma_chk (
  input wire                                   clk,
  input wire                                   rst_n,
  input wire                                   in_valid,
  input wire                                   in_stall,
  input wire                                   out_valid,
  input wire                                   out_stall,
  input wire  signed [ehma_pkg::SAMPLE_W-1:0]  out_hull_value,
  input wire                                   cfg_ready
);
  import ehma_pkg::*;

  // one word in flight: input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted again while a word is in flight");

  // no result can appear the cycle after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared one cycle after accept");

  // a new result only shows once the sequencer is back to taking words
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while input still closed");

  // stalled result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_hull_value)))
    else $error("stalled result word changed or dropped");

  // gain writes are always taken
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind exponential_hull_moving_average_top ehma_chk u_ehma_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hull_value (out_hull_value),
  .cfg_ready      (cfg_ready)
);

`default_nettype wire

// ----- verif/tb_exponential_hull_moving_average_top.sv -----
`timescale 1ns / 1ps
// tb_exponential_hull_moving_average_top: self-checking bench for the hull moving average block
// depends on ehma_pkg and exponential_hull_moving_average_top

// tracks the three averages and queues the hull words they predict
class hull_scoreboard;
  logic [ehma_pkg::GAIN_W-1:0] gain_half;
  logic [ehma_pkg::GAIN_W-1:0] gain_full;
  logic [ehma_pkg::GAIN_W-1:0] gain_root;
  bit primed;
  logic signed [ehma_pkg::SAMPLE_W-1:0] avg_half;
  logic signed [ehma_pkg::SAMPLE_W-1:0] avg_full;
  logic signed [ehma_pkg::SAMPLE_W-1:0] avg_hull;
  logic signed [ehma_pkg::SAMPLE_W-1:0] hull_queue[$];
  int errors;

  function new();
    gain_half = ehma_pkg::GAIN_ONE;
    gain_full = ehma_pkg::GAIN_ONE;
    gain_root = ehma_pkg::GAIN_ONE;
    primed = 1'b0;
    avg_half = '0;
    avg_full = '0;
    avg_hull = '0;
    errors = 0;
  endfunction

  // clamp to the q16.16 range
  function logic signed [ehma_pkg::SAMPLE_W-1:0] clamp_q(input longint v);
    if (v > longint'(ehma_pkg::Q_MAX)) return ehma_pkg::Q_MAX;
    if (v < longint'(ehma_pkg::Q_MIN)) return ehma_pkg::Q_MIN;
    return v[ehma_pkg::SAMPLE_W-1:0];
  endfunction

  // one smoothing step toward target, rounding half up after the q16 shift
  function logic signed [ehma_pkg::SAMPLE_W-1:0] ema_move(
    input logic signed [ehma_pkg::SAMPLE_W-1:0] avg,
    input longint target,
    input logic [ehma_pkg::GAIN_W-1:0] gain
  );
    longint diff;
    longint prod;
    diff = target - longint'(avg);
    prod = diff * longint'(gain) + 64'sd32768;
    return clamp_q(longint'(avg) + (prod >>> 16));
  endfunction

  // gain register write, unknown indexes are dropped
  function void set_gain(input logic [ehma_pkg::CFG_IDX_W-1:0] idx,
                         input logic [ehma_pkg::GAIN_W-1:0] data);
    case (idx)
      ehma_pkg::CFG_GAIN_HALF: gain_half = data;
      ehma_pkg::CFG_GAIN_FULL: gain_full = data;
      ehma_pkg::CFG_GAIN_ROOT: gain_root = data;
      default: ;
    endcase
  endfunction

  // accepted sample: advance the averages and queue the new hull word
  function void note_sample(input logic signed [ehma_pkg::SAMPLE_W-1:0] s);
    logic signed [ehma_pkg::SAMPLE_W-1:0] hull_target;
    if (!primed) begin
      avg_half = s;
      avg_full = s;
      avg_hull = s;
      primed = 1'b1;
    end else begin
      avg_half = ema_move(avg_half, longint'(s), gain_half);
      avg_full = ema_move(avg_full, longint'(s), gain_full);
      hull_target = clamp_q(2 * longint'(avg_half) - longint'(avg_full));
      avg_hull = ema_move(avg_hull, longint'(hull_target), gain_root);
    end
    hull_queue.push_back(avg_hull);
  endfunction

  task report_mismatch(input string msg);
    errors++;
    $display("hull mismatch: %s", msg);
  endtask

  // accepted result word against the oldest prediction
  task check_hull(input logic signed [ehma_pkg::SAMPLE_W-1:0] got);
    logic signed [ehma_pkg::SAMPLE_W-1:0] want;
    if (hull_queue.size() == 0) begin
      report_mismatch($sformatf("hull_value %0d with nothing pending", got));
    end else begin
      want = hull_queue.pop_front();
      if (got !== want)
        report_mismatch($sformatf("hull_value got %0d want %0d", got, want));
    end
  endtask
endclass

module tb_exponential_hull_moving_average_top;

  localparam logic [ehma_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [ehma_pkg::GAIN_W-1:0] GAIN_MAX = 17'd131071;
  localparam logic [ehma_pkg::GAIN_W-1:0] GAIN_HALF_LSB_TIE = 17'd32768;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int GAIN_ROUNDS = 8;
  localparam int WORDS_PER_ROUND = 180;
  localparam int HOLD_ROUND = 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ehma_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ehma_pkg::SAMPLE_W-1:0] out_hull_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ehma_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [ehma_pkg::GAIN_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int hold_left = 0;
  int cycles = 0;
  logic signed [ehma_pkg::SAMPLE_W-1:0] last_sample = '0;
  hull_scoreboard sb;

  always #1 clk = ~clk;

  exponential_hull_moving_average_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hull_value(out_hull_value),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // input, result and gain monitors
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_sample(in_sample);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_hull(out_hull_value);
  end

  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) sb.set_gain(cfg_index, cfg_data);
  end

  // receiver stall: random per phase, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // offer one sample word; valid stays high after accept unless a gap follows
  task automatic send_sample(input logic signed [ehma_pkg::SAMPLE_W-1:0] s);
    in_valid <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // stop sending and wait for every predicted hull word
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.hull_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the three gains back to back, optionally also the unused index
  task automatic load_gains(input logic [ehma_pkg::GAIN_W-1:0] g_half,
                            input logic [ehma_pkg::GAIN_W-1:0] g_full,
                            input logic [ehma_pkg::GAIN_W-1:0] g_root,
                            input bit poke_unused);
    logic [ehma_pkg::CFG_IDX_W-1:0] idx[4];
    logic [ehma_pkg::GAIN_W-1:0] val[4];
    int n;
    idx = '{ehma_pkg::CFG_GAIN_HALF, ehma_pkg::CFG_GAIN_FULL, ehma_pkg::CFG_GAIN_ROOT,
            CFG_UNUSED};
    val = '{g_half, g_full, g_root, 17'($urandom)};
    n = poke_unused ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // extremes, small values, full random words and a random walk
  function automatic logic signed [ehma_pkg::SAMPLE_W-1:0] pick_sample(
    input logic signed [ehma_pkg::SAMPLE_W-1:0] prev
  );
    longint walk;
    case ($urandom_range(9))
      0: return ehma_pkg::Q_MAX;
      1: return ehma_pkg::Q_MIN;
      2: return 32'($urandom_range(64)) - 32'd32;
      3, 4: return $urandom;
      default: begin
        walk = longint'(prev) + longint'($urandom_range(1 << 20)) - 64'sd524288;
        if (walk > longint'(ehma_pkg::Q_MAX)) walk = longint'(ehma_pkg::Q_MAX);
        if (walk < longint'(ehma_pkg::Q_MIN)) walk = longint'(ehma_pkg::Q_MIN);
        return walk[31:0];
      end
    endcase
  endfunction

  function automatic logic [ehma_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(4))
      0: return '0;
      1: return GAIN_MAX;
      2: return ehma_pkg::GAIN_ONE;
      default: return 17'($urandom);
    endcase
  endfunction

  initial begin
    int period;
    int root;
    logic [ehma_pkg::GAIN_W-1:0] g_half;
    logic [ehma_pkg::GAIN_W-1:0] g_full;
    logic [ehma_pkg::GAIN_W-1:0] g_root;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first sample primes all averages, then full-swing steps at unity gain
    send_sample(ehma_pkg::Q_MIN);
    send_sample(ehma_pkg::Q_MAX);
    send_sample(ehma_pkg::Q_MIN);
    send_sample(32'sd0);
    send_sample(32'sd1);
    send_sample(-32'sd1);
    wait_drain();

    // largest gains overshoot and saturate
    load_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
    send_sample(ehma_pkg::Q_MAX);
    send_sample(ehma_pkg::Q_MIN);
    send_sample(ehma_pkg::Q_MAX);
    send_sample(ehma_pkg::Q_MIN);
    send_sample(32'sd12345);
    wait_drain();

    // zero gains freeze the averages
    load_gains('0, '0, '0, 1'b0);
    send_sample(32'sd1);
    send_sample(ehma_pkg::Q_MAX);
    wait_drain();

    // half gains near zero land on rounding ties
    load_gains(GAIN_HALF_LSB_TIE, GAIN_HALF_LSB_TIE, GAIN_HALF_LSB_TIE, 1'b0);
    send_sample(32'sd0);
    send_sample(32'sd1);
    send_sample(32'sd0);
    send_sample(-32'sd1);
    send_sample(32'sd1);
    wait_drain();

    // mixed gains
    load_gains(ehma_pkg::GAIN_ONE, '0, GAIN_MAX, 1'b0);
    send_sample(ehma_pkg::Q_MAX);
    send_sample(ehma_pkg::Q_MIN);
    send_sample(32'sd0);
    wait_drain();

    // random rounds, each with its own gains and idling mode
    for (int round = 0; round < GAIN_ROUNDS; round++) begin
      if ($urandom_range(1)) begin
        period = $urandom_range(400, 4);
        root = 1;
        while ((root + 1) * (root + 1) <= period) root++;
        g_half = 17'(131072 / (period / 2 + 1));
        g_full = 17'(131072 / (period + 1));
        g_root = 17'(131072 / (root + 1));
      end else begin
        g_half = pick_gain();
        g_full = pick_gain();
        g_root = pick_gain();
      end
      load_gains(g_half, g_full, g_root, round == 0);
      case (round % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 60; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 60; end
        default: begin send_idle_pct <= 8; recv_stall_pct <= 8; end
      endcase
      for (int i = 0; i < WORDS_PER_ROUND; i++) begin
        // long receiver hold-off while words keep coming
        if (round == HOLD_ROUND && i == 30) hold_go <= ~hold_go;
        // sender pause until the pipe is empty
        if (i == WORDS_PER_ROUND / 2) wait_drain();
        last_sample = pick_sample(last_sample);
        send_sample(last_sample);
      end
      wait_drain();
    end

    if (sb.hull_queue.size() != 0)
      sb.report_mismatch($sformatf("%0d hull words never arrived", sb.hull_queue.size()));
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/ehma_pkg.sv
src/ehma_dp.sv
src/ehma_ctrl.sv
src/exponential_hull_moving_average_top.sv
src/ehma_chk.sv
verif/tb_exponential_hull_moving_average_top.sv
